/* rtl/uart_buffered_rx_tx_fifo_top_defines.svh */
// Assertion macros used by the checker file.
`ifndef UART_BUFFERED_RX_TX_FIFO_TOP_DEFINES_SVH
`define UART_BUFFERED_RX_TX_FIFO_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clock and disabled in reset.
`define UBRTF_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock and disabled in reset.
`define UBRTF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/ubrtf_pkg.sv */
// ----------------------------------------------------------------------------
// ubrtf_pkg
// Types and codes of the buffered serial-port rings with error counters.
// ----------------------------------------------------------------------------
package ubrtf_pkg;

   // request kinds
   localparam logic [2:0] REQ_ARRIVAL  = 3'd0;
   localparam logic [2:0] REQ_TX_READY = 3'd1;
   localparam logic [2:0] REQ_PUSH     = 3'd2;
   localparam logic [2:0] REQ_POP      = 3'd3;
   localparam logic [2:0] REQ_CNT_READ = 3'd4;

   // counter indexes
   localparam logic [2:0] CNT_RX_BYTES  = 3'd0;
   localparam logic [2:0] CNT_TX_BYTES  = 3'd1;
   localparam logic [2:0] CNT_PARITY    = 3'd2;
   localparam logic [2:0] CNT_FRAMING   = 3'd3;
   localparam logic [2:0] CNT_OVERRUN   = 3'd4;
   localparam logic [2:0] CNT_OVERFLOW  = 3'd5;
   localparam logic [2:0] CNT_RX_EVENTS = 3'd6;
   localparam logic [2:0] CNT_TX_EVENTS = 3'd7;

   localparam int NUM_COUNTERS = 8;

   // event status codes
   localparam logic [2:0] EVT_OK       = 3'd0;
   localparam logic [2:0] EVT_PARITY   = 3'd1;
   localparam logic [2:0] EVT_FRAMING  = 3'd2;
   localparam logic [2:0] EVT_OVERRUN  = 3'd3;
   localparam logic [2:0] EVT_OVERFLOW = 3'd4;

   typedef struct packed {
      logic [2:0] req_type;
      logic [7:0] data_byte;
      logic       parity_flag;
      logic       framing_flag;
      logic       overrun_flag;
      logic [2:0] counter_select;
   } req_beat_type;

   typedef struct packed {
      logic [7:0]  host_byte;
      logic        host_byte_valid;
      logic [7:0]  line_byte;
      logic        line_byte_valid;
      logic        push_refused;
      logic [2:0]  event_status;
      logic        rx_not_empty;
      logic        tx_is_empty;
      logic        tx_irq_on;
      logic [31:0] counter_value;
   } rsp_beat_type;

   // controller to datapath
   typedef struct packed {
      logic load;   // capture request, read rings and counter
      logic exec;   // update state, register result
   } cmd_type;

endpackage

/* rtl/ubrtf_ctrl.sv */
// ----------------------------------------------------------------------------
// ubrtf_ctrl
// Two-state sequencer: capture a request, then execute it and strobe result.
// ----------------------------------------------------------------------------
module ubrtf_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   output logic              rsp_strobe,
   output ubrtf_pkg::cmd_type cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic state_ff, state_in;
   logic strobe_ff, strobe_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign cmd.load  = (state_ff == ST_IDLE) && start;
   assign cmd.exec  = (state_ff == ST_EXEC);
   assign strobe_in = cmd.exec;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   assign busy       = (state_ff == ST_EXEC);
   assign rsp_strobe = strobe_ff;

endmodule

/* rtl/ubrtf_datapath.sv */
// ----------------------------------------------------------------------------
// ubrtf_datapath
// Receive and transmit rings, ring pointers, interrupt enable and counters.
// ----------------------------------------------------------------------------
module ubrtf_datapath #(
   parameter int RX_DEPTH    = 16,
   parameter int TX_DEPTH    = 16,
   parameter int COUNT_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ubrtf_pkg::cmd_type      cmd,
   input  ubrtf_pkg::req_beat_type req_beat,
   output ubrtf_pkg::rsp_beat_type rsp_beat
);

   localparam int RX_AW = $clog2(RX_DEPTH);
   localparam int TX_AW = $clog2(TX_DEPTH);
   localparam logic [RX_AW-1:0] RX_LAST = RX_AW'(RX_DEPTH - 1);
   localparam logic [TX_AW-1:0] TX_LAST = TX_AW'(TX_DEPTH - 1);

   logic [7:0] rx_mem [RX_DEPTH];
   logic [7:0] tx_mem [TX_DEPTH];

   ubrtf_pkg::req_beat_type req_ff;
   logic [7:0]             rx_rd_data_ff;
   logic [7:0]             tx_rd_data_ff;
   logic [COUNT_WIDTH-1:0] cnt_rd_ff;
   logic [COUNT_WIDTH-1:0] cnt_ff [ubrtf_pkg::NUM_COUNTERS];

   logic [RX_AW-1:0] rx_wr_ptr_ff, rx_wr_ptr_in, rx_rd_ptr_ff, rx_rd_ptr_in, rx_nx;
   logic [TX_AW-1:0] tx_wr_ptr_ff, tx_wr_ptr_in, tx_rd_ptr_ff, tx_rd_ptr_in, tx_nx, tx_rd_nx;
   logic [RX_AW-1:0] rx_rd_nx;
   logic             irq_ff, irq_in;
   logic             rx_we, tx_we;
   logic [ubrtf_pkg::NUM_COUNTERS-1:0] bump;
   logic             rx_full, rx_empty, tx_full, tx_empty;

   ubrtf_pkg::rsp_beat_type rsp_ff, rsp_in;

   assign rx_nx    = (rx_wr_ptr_ff == RX_LAST) ? '0 : rx_wr_ptr_ff + 1'b1;
   assign rx_rd_nx = (rx_rd_ptr_ff == RX_LAST) ? '0 : rx_rd_ptr_ff + 1'b1;
   assign tx_nx    = (tx_wr_ptr_ff == TX_LAST) ? '0 : tx_wr_ptr_ff + 1'b1;
   assign tx_rd_nx = (tx_rd_ptr_ff == TX_LAST) ? '0 : tx_rd_ptr_ff + 1'b1;
   assign rx_full  = (rx_nx == rx_rd_ptr_ff);
   assign rx_empty = (rx_rd_ptr_ff == rx_wr_ptr_ff);
   assign tx_full  = (tx_nx == tx_rd_ptr_ff);
   assign tx_empty = (tx_rd_ptr_ff == tx_wr_ptr_ff);

   always_comb begin
      rx_wr_ptr_in = rx_wr_ptr_ff;
      rx_rd_ptr_in = rx_rd_ptr_ff;
      tx_wr_ptr_in = tx_wr_ptr_ff;
      tx_rd_ptr_in = tx_rd_ptr_ff;
      irq_in       = irq_ff;
      rx_we        = 1'b0;
      tx_we        = 1'b0;
      bump         = '0;
      rsp_in       = '0;
      case (req_ff.req_type)
         ubrtf_pkg::REQ_ARRIVAL: begin
            bump[ubrtf_pkg::CNT_RX_EVENTS] = 1'b1;
            // parity beats framing beats overrun
            if (req_ff.parity_flag) begin
               bump[ubrtf_pkg::CNT_PARITY] = 1'b1;
               rsp_in.event_status         = ubrtf_pkg::EVT_PARITY;
            end else if (req_ff.framing_flag) begin
               bump[ubrtf_pkg::CNT_FRAMING] = 1'b1;
               rsp_in.event_status          = ubrtf_pkg::EVT_FRAMING;
            end else if (req_ff.overrun_flag) begin
               bump[ubrtf_pkg::CNT_OVERRUN] = 1'b1;
               rsp_in.event_status          = ubrtf_pkg::EVT_OVERRUN;
            end else if (!rx_full) begin
               rx_we                         = 1'b1;
               rx_wr_ptr_in                  = rx_nx;
               bump[ubrtf_pkg::CNT_RX_BYTES] = 1'b1;
            end else begin
               bump[ubrtf_pkg::CNT_OVERFLOW] = 1'b1;
               rsp_in.event_status           = ubrtf_pkg::EVT_OVERFLOW;
            end
         end
         ubrtf_pkg::REQ_TX_READY: begin
            bump[ubrtf_pkg::CNT_TX_EVENTS] = 1'b1;
            if (!tx_empty) begin
               bump[ubrtf_pkg::CNT_TX_BYTES] = 1'b1;
               rsp_in.line_byte              = tx_rd_data_ff;
               rsp_in.line_byte_valid        = 1'b1;
               tx_rd_ptr_in                  = tx_rd_nx;
            end else begin
               irq_in = 1'b0;
            end
         end
         ubrtf_pkg::REQ_PUSH: begin
            if (tx_full) begin
               rsp_in.push_refused = 1'b1;
            end else begin
               if (tx_empty) irq_in = 1'b1;
               tx_we        = 1'b1;
               tx_wr_ptr_in = tx_nx;
            end
         end
         ubrtf_pkg::REQ_POP: begin
            if (!rx_empty) begin
               rsp_in.host_byte       = rx_rd_data_ff;
               rsp_in.host_byte_valid = 1'b1;
               rx_rd_ptr_in           = rx_rd_nx;
            end
         end
         ubrtf_pkg::REQ_CNT_READ: begin
            rsp_in.counter_value = 32'(cnt_rd_ff);
         end
         default: begin
         end
      endcase
      rsp_in.rx_not_empty = (rx_rd_ptr_in != rx_wr_ptr_in);
      rsp_in.tx_is_empty  = (tx_rd_ptr_in == tx_wr_ptr_in);
      rsp_in.tx_irq_on    = irq_in;
   end

   // ring storage: one write, one registered read
   always_ff @(posedge clock) begin
      if (cmd.exec && rx_we) rx_mem[rx_wr_ptr_ff] <= req_ff.data_byte;
      if (cmd.load) rx_rd_data_ff <= rx_mem[rx_rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.exec && tx_we) tx_mem[tx_wr_ptr_ff] <= req_ff.data_byte;
      if (cmd.load) tx_rd_data_ff <= tx_mem[tx_rd_ptr_ff];
   end

   // payload capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff    <= req_beat;
         cnt_rd_ff <= cnt_ff[req_beat.counter_select];
      end
      if (cmd.exec) rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_wr_ptr_ff <= '0;
         rx_rd_ptr_ff <= '0;
         tx_wr_ptr_ff <= '0;
         tx_rd_ptr_ff <= '0;
         irq_ff       <= 1'b0;
      end else if (cmd.exec) begin
         rx_wr_ptr_ff <= rx_wr_ptr_in;
         rx_rd_ptr_ff <= rx_rd_ptr_in;
         tx_wr_ptr_ff <= tx_wr_ptr_in;
         tx_rd_ptr_ff <= tx_rd_ptr_in;
         irq_ff       <= irq_in;
      end
   end

   // counters wrap at COUNT_WIDTH bits
   always_ff @(posedge clock) begin
      for (int i = 0; i < ubrtf_pkg::NUM_COUNTERS; i++) begin
         if (reset) begin
            cnt_ff[i] <= '0;
         end else if (cmd.exec && bump[i]) begin
            cnt_ff[i] <= cnt_ff[i] + COUNT_WIDTH'(1);
         end
      end
   end

   assign rsp_beat = rsp_ff;

endmodule

/* rtl/uart_buffered_rx_tx_fifo_top.sv */
// A request accepted while idle is captured, reading its ring byte and counter;
// the execute state then updates the rings and registers the result beat,
// and the result strobe is registered from the execute state. No new request
// is taken while busy, in the execute state that follows every capture.
// Reset (synchronous, active high) empties both rings, clears the transmit
// interrupt enable and all counters; ring contents are not cleared.
// ----------------------------------------------------------------------------
// uart_buffered_rx_tx_fifo_top
// Buffered serial-port receive/transmit rings with error and event counters.
// ----------------------------------------------------------------------------
module uart_buffered_rx_tx_fifo_top #(
   parameter int RX_DEPTH    = 16,
   parameter int TX_DEPTH    = 16,
   parameter int COUNT_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  ubrtf_pkg::req_beat_type req_beat,
   output logic                   rsp_strobe,
   output ubrtf_pkg::rsp_beat_type rsp_beat
);

   ubrtf_pkg::cmd_type cmd;

   ubrtf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd)
   );

   ubrtf_datapath #(
      .RX_DEPTH    (RX_DEPTH),
      .TX_DEPTH    (TX_DEPTH),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_beat (req_beat),
      .rsp_beat (rsp_beat)
   );

endmodule

/* rtl/ubrtf_chk.sv */
// ----------------------------------------------------------------------------
// ubrtf_chk
// Port-level checks on request/result timing and result consistency.
// ----------------------------------------------------------------------------
`include "uart_buffered_rx_tx_fifo_top_defines.svh"

module ubrtf_chk (
   input logic                    clock,
   input logic                    reset,
   input logic                    start,
   input logic                    busy,
   input logic                    rsp_strobe,
   input ubrtf_pkg::rsp_beat_type rsp_beat
);

   `UBRTF_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted beat did not raise busy")
   `UBRTF_ASSERT_NEXT(a_busy_strobe, busy, rsp_strobe && !busy, "no result beat after execute")
   `UBRTF_ASSERT_NOW(a_strobe_free, rsp_strobe, !busy, "result beat while busy")
   `UBRTF_ASSERT_NOW(a_one_byte, rsp_strobe, !(rsp_beat.host_byte_valid && rsp_beat.line_byte_valid), "both byte valids set")
   `UBRTF_ASSERT_NOW(a_refused_full, rsp_strobe && rsp_beat.push_refused, !rsp_beat.tx_is_empty, "push refused on empty ring")

endmodule

bind uart_buffered_rx_tx_fifo_top ubrtf_chk u_chk (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_beat   (rsp_beat)
);
